@@ rtl/cssrc_pkg.sv @@
// ----------------------------------------------------------------------------
// cssrc_pkg: shared types and constants of the start relay controller
// Register indexes, reset values, event codes and the control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package cssrc_pkg;

	// default parameter values
	localparam int AVERAGE_DEPTH_DEF = 8;
	localparam int SAMPLE_BITS_DEF   = 10;

	// register field widths
	localparam int THR_W  = 10;
	localparam int WIN_W  = 10;
	localparam int TIME_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_THRESHOLD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_TIMEOUT_MS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE_MS         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_HOLD_MS    = 3'd4;

	// register reset values
	localparam logic [THR_W-1:0]  THRESHOLD_RST  = 10'd740;
	localparam logic [WIN_W-1:0]  WINDOW_RST     = 10'd100;
	localparam logic [TIME_W-1:0] TIMEOUT_RST    = 16'd6000;
	localparam logic [TIME_W-1:0] PAUSE_RST      = 16'd1000;
	localparam logic [TIME_W-1:0] ALARM_HOLD_RST = 16'd4000;

	// item kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	// tone event codes
	localparam logic [1:0] TONE_NONE  = 2'd0;
	localparam logic [1:0] TONE_READY = 2'd1;
	localparam logic [1:0] TONE_START = 2'd2;
	localparam logic [1:0] TONE_FAIL  = 2'd3;

	// start result codes
	localparam logic [1:0] RES_NONE    = 2'd0;
	localparam logic [1:0] RES_OK      = 2'd1;
	localparam logic [1:0] RES_TIMEOUT = 2'd2;

	// configuration register set
	typedef struct packed {
		logic [THR_W-1:0]  start_threshold;
		logic [WIN_W-1:0]  window_ms;
		logic [TIME_W-1:0] start_timeout_ms;
		logic [TIME_W-1:0] pause_ms;
		logic [TIME_W-1:0] alarm_hold_ms;
	} cfg_t;

	// sequencer to filter control
	typedef struct packed {
		logic measuring;
		logic clear;
	} flt_ctl_t;

	// sequencer result flags of one item
	typedef struct packed {
		logic       start_relay_on;
		logic       alarm_relay_on;
		logic [1:0] tone_event;
		logic       window_done;
		logic [1:0] start_result;
	} seq_res_t;

endpackage

`default_nettype wire

@@ rtl/cssrc_filter.sv @@
// ----------------------------------------------------------------------------
// cssrc_filter: moving average and window peak
// Modified moving average seeded by the first sample, with the peak of the
// filtered values kept until the sequencer clears it.
// ----------------------------------------------------------------------------
`default_nettype none

module cssrc_filter #(
	parameter int AVERAGE_DEPTH = cssrc_pkg::AVERAGE_DEPTH_DEF,
	parameter int SAMPLE_BITS   = cssrc_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   fire,
	input  wire logic                   kind,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire cssrc_pkg::flt_ctl_t    ctl,
	output logic      [SAMPLE_BITS-1:0] peak,
	output logic      [SAMPLE_BITS-1:0] avg_nxt
);

	// sum stays below AVERAGE_DEPTH * 2^SAMPLE_BITS
	localparam int DIV_L   = $clog2(AVERAGE_DEPTH);
	localparam int SUM_W   = DIV_L + SAMPLE_BITS;
	localparam int SHIFT   = SUM_W + DIV_L;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	// exact reciprocal for dividends below 2^SUM_W
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) + 64'(AVERAGE_DEPTH) - 64'd1) / 64'(AVERAGE_DEPTH));

	logic [SUM_W-1:0]       sum_q, sum_nxt;
	logic [SAMPLE_BITS-1:0] avg_q;
	logic [SAMPLE_BITS-1:0] peak_q, peak_nxt;
	logic                   seeded_q, seeded_nxt;
	logic [SUM_W:0]         sum_upd;
	logic [PROD_W-1:0]      prod;

	// running sum update and division by the depth
	always_comb begin
		sum_upd    = {1'b0, sum_q} - (SUM_W+1)'(avg_q) + (SUM_W+1)'(sample);
		sum_nxt    = sum_q;
		avg_nxt    = avg_q;
		seeded_nxt = seeded_q;
		prod       = PROD_W'(sum_upd[SUM_W-1:0]) * PROD_W'(RECIP);
		peak_nxt   = peak_q;
		if (fire && kind == cssrc_pkg::KIND_SAMPLE && ctl.measuring) begin
			seeded_nxt = 1'b1;
			if (!seeded_q) begin
				sum_nxt = SUM_W'(sample) * SUM_W'(AVERAGE_DEPTH);
				avg_nxt = sample;
			end else begin
				sum_nxt = sum_upd[SUM_W-1:0];
				avg_nxt = prod[SHIFT +: SAMPLE_BITS];
			end
			if (avg_nxt > peak_q)
				peak_nxt = avg_nxt;
		end
		if (fire && kind == cssrc_pkg::KIND_TICK && ctl.clear)
			peak_nxt = '0;
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			avg_q    <= '0;
			seeded_q <= 1'b0;
			peak_q   <= '0;
		end else begin
			sum_q    <= sum_nxt;
			avg_q    <= avg_nxt;
			seeded_q <= seeded_nxt;
			peak_q   <= peak_nxt;
		end
	end

	assign peak = peak_q;

endmodule

`default_nettype wire

@@ rtl/cssrc_seq.sv @@
// ----------------------------------------------------------------------------
// cssrc_seq: window and phase sequencer
// Counts window ticks, runs the measure / start / alarm / pause phases and
// the start timer, and forms the relay and event flags of each item.
// ----------------------------------------------------------------------------
`default_nettype none

module cssrc_seq #(
	parameter int SAMPLE_BITS = cssrc_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   fire,
	input  wire logic                   kind,
	input  wire logic [SAMPLE_BITS-1:0] peak,
	input  wire cssrc_pkg::cfg_t        cfg,
	output cssrc_pkg::flt_ctl_t         ctl,
	output cssrc_pkg::seq_res_t         res,
	output logic      [SAMPLE_BITS-1:0] window_peak
);

	localparam int WIN_W  = cssrc_pkg::WIN_W;
	localparam int TIME_W = cssrc_pkg::TIME_W;
	localparam int CMP_W  = (SAMPLE_BITS > cssrc_pkg::THR_W) ? SAMPLE_BITS : cssrc_pkg::THR_W;

	typedef enum logic [2:0] {
		PH_INIT,
		PH_MEASURE,
		PH_STARTING,
		PH_ALARM,
		PH_PAUSE
	} phase_t;

	phase_t              phase_q, phase_nxt;
	logic [WIN_W-1:0]    win_cnt_q, win_cnt_nxt;
	logic [TIME_W-1:0]   phase_tmr_q, phase_tmr_nxt;
	logic [TIME_W-1:0]   start_tmr_q, start_tmr_nxt;
	logic [WIN_W:0]      cnt_inc;
	logic [WIN_W:0]      win_len;
	logic [TIME_W:0]     pt_inc;
	logic [TIME_W:0]     st_inc;
	logic [CMP_W-1:0]    peak_x;
	logic [CMP_W-1:0]    thr_x;
	logic                tick;
	logic                measuring;
	logic                done;
	logic                clear;
	logic [1:0]          tone;
	logic [1:0]          result;

	// window counting and phase transitions
	always_comb begin
		tick      = fire && kind == cssrc_pkg::KIND_TICK;
		measuring = phase_q == PH_INIT || phase_q == PH_MEASURE || phase_q == PH_STARTING;
		cnt_inc   = {1'b0, win_cnt_q} + (WIN_W+1)'(1);
		win_len   = (cfg.window_ms == '0) ? (WIN_W+1)'(1) : {1'b0, cfg.window_ms};
		pt_inc    = {1'b0, phase_tmr_q} + (TIME_W+1)'(1);
		st_inc    = {1'b0, start_tmr_q} + (TIME_W+1)'(1);
		peak_x    = CMP_W'(peak);
		thr_x     = CMP_W'(cfg.start_threshold);

		done          = tick && measuring && cnt_inc >= win_len;
		clear         = done;
		tone          = cssrc_pkg::TONE_NONE;
		result        = cssrc_pkg::RES_NONE;
		phase_nxt     = phase_q;
		phase_tmr_nxt = phase_tmr_q;
		start_tmr_nxt = start_tmr_q;
		win_cnt_nxt   = win_cnt_q;
		if (tick && measuring)
			win_cnt_nxt = done ? '0 : cnt_inc[WIN_W-1:0];

		if (tick) begin
			case (phase_q)
				PH_INIT: begin
					if (done) begin
						tone      = cssrc_pkg::TONE_READY;
						phase_nxt = PH_MEASURE;
					end
				end
				PH_MEASURE: begin
					if (done) begin
						if (peak_x > thr_x) begin
							tone          = cssrc_pkg::TONE_START;
							start_tmr_nxt = '0;
							phase_nxt     = PH_STARTING;
						end else begin
							phase_tmr_nxt = '0;
							phase_nxt     = PH_PAUSE;
						end
					end
				end
				PH_STARTING: begin
					start_tmr_nxt = st_inc[TIME_W-1:0];
					// success wins over a timeout on the same tick
					if (done && peak_x < thr_x) begin
						result        = cssrc_pkg::RES_OK;
						phase_tmr_nxt = '0;
						phase_nxt     = PH_PAUSE;
					end else if (st_inc >= {1'b0, cfg.start_timeout_ms}) begin
						result        = cssrc_pkg::RES_TIMEOUT;
						tone          = cssrc_pkg::TONE_FAIL;
						phase_tmr_nxt = '0;
						phase_nxt     = PH_ALARM;
						clear         = 1'b1;
						win_cnt_nxt   = '0;
					end
				end
				PH_ALARM: begin
					if (pt_inc >= {1'b0, cfg.alarm_hold_ms}) begin
						phase_tmr_nxt = '0;
						phase_nxt     = PH_PAUSE;
					end else begin
						phase_tmr_nxt = pt_inc[TIME_W-1:0];
					end
				end
				default: begin
					if (pt_inc >= {1'b0, cfg.pause_ms}) begin
						phase_tmr_nxt = '0;
						phase_nxt     = PH_MEASURE;
						clear         = 1'b1;
						win_cnt_nxt   = '0;
					end else begin
						phase_tmr_nxt = pt_inc[TIME_W-1:0];
					end
				end
			endcase
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_INIT;
			win_cnt_q   <= '0;
			phase_tmr_q <= '0;
			start_tmr_q <= '0;
		end else begin
			phase_q     <= phase_nxt;
			win_cnt_q   <= win_cnt_nxt;
			phase_tmr_q <= phase_tmr_nxt;
			start_tmr_q <= start_tmr_nxt;
		end
	end

	// flags of this item
	always_comb begin
		ctl.measuring      = measuring;
		ctl.clear          = clear;
		res.start_relay_on = phase_nxt == PH_STARTING;
		res.alarm_relay_on = phase_nxt == PH_ALARM;
		res.tone_event     = tone;
		res.window_done    = done;
		res.start_result   = result;
		window_peak        = done ? peak : '0;
	end

endmodule

`default_nettype wire

@@ rtl/current_sensed_start_relay_controller_top.sv @@
// ----------------------------------------------------------------------------
// current_sensed_start_relay_controller_top: current-sensed start relay control
// Path: an accepted item waits in the input register, then goes through one pass
// of filter and sequencer logic into the result register.
// Throughput: one item per cycle unless out_stall holds the result register; the filter's state update sets it.
// Reset: control, filter and sequencer state clear; registers take defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module current_sensed_start_relay_controller_top #(
	parameter int AVERAGE_DEPTH = cssrc_pkg::AVERAGE_DEPTH_DEF,
	parameter int SAMPLE_BITS   = cssrc_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration
	input  wire logic                                cfg_we,
	input  wire logic [cssrc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [cssrc_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input items
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                kind,
	input  wire logic [SAMPLE_BITS-1:0]              sample,
	// result items
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     start_relay_on,
	output logic                                     alarm_relay_on,
	output logic [1:0]                               tone_event,
	output logic                                     window_done,
	output logic [SAMPLE_BITS-1:0]                   window_peak,
	output logic [SAMPLE_BITS-1:0]                   filtered_value,
	output logic [1:0]                               start_result
);

	cssrc_pkg::cfg_t     cfg_q;
	cssrc_pkg::flt_ctl_t flt_ctl;
	cssrc_pkg::seq_res_t seq_res;

	logic                   valid_s1;
	logic                   kind_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   adv;
	logic                   fire;
	logic [SAMPLE_BITS-1:0] peak;
	logic [SAMPLE_BITS-1:0] avg_nxt;
	logic [SAMPLE_BITS-1:0] wpeak;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_threshold  <= cssrc_pkg::THRESHOLD_RST;
			cfg_q.window_ms        <= cssrc_pkg::WINDOW_RST;
			cfg_q.start_timeout_ms <= cssrc_pkg::TIMEOUT_RST;
			cfg_q.pause_ms         <= cssrc_pkg::PAUSE_RST;
			cfg_q.alarm_hold_ms    <= cssrc_pkg::ALARM_HOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cssrc_pkg::REG_START_THRESHOLD:
					cfg_q.start_threshold <= cfg_data[cssrc_pkg::THR_W-1:0];
				cssrc_pkg::REG_WINDOW_MS:
					cfg_q.window_ms <= cfg_data[cssrc_pkg::WIN_W-1:0];
				cssrc_pkg::REG_START_TIMEOUT_MS:
					cfg_q.start_timeout_ms <= cfg_data;
				cssrc_pkg::REG_PAUSE_MS:
					cfg_q.pause_ms <= cfg_data;
				cssrc_pkg::REG_ALARM_HOLD_MS:
					cfg_q.alarm_hold_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	// flow control: the result register frees or drains every cycle it is not stalled
	assign adv      = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign fire     = valid_s1 && adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1   <= kind;
			sample_s1 <= sample;
		end
	end

	cssrc_filter #(
		.AVERAGE_DEPTH (AVERAGE_DEPTH),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_filter (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.kind    (kind_s1),
		.sample  (sample_s1),
		.ctl     (flt_ctl),
		.peak    (peak),
		.avg_nxt (avg_nxt)
	);

	cssrc_seq #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.kind        (kind_s1),
		.peak        (peak),
		.cfg         (cfg_q),
		.ctl         (flt_ctl),
		.res         (seq_res),
		.window_peak (wpeak)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			start_relay_on <= seq_res.start_relay_on;
			alarm_relay_on <= seq_res.alarm_relay_on;
			tone_event     <= seq_res.tone_event;
			window_done    <= seq_res.window_done;
			window_peak    <= wpeak;
			filtered_value <= avg_nxt;
			start_result   <= seq_res.start_result;
		end
	end

	// relays are never both on
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(start_relay_on && alarm_relay_on))
		else $error("start and alarm relay both on");

	// a timed-out start goes with the failure tone and the alarm relay
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && start_result == cssrc_pkg::RES_TIMEOUT) |->
			(tone_event == cssrc_pkg::TONE_FAIL && alarm_relay_on))
		else $error("timeout result without failure tone and alarm");

	// a window peak is reported only when a window closes
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !window_done) |-> (window_peak == '0))
		else $error("window peak without a closed window");

	// an item held in the input register moves on once the result register drains
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_stall) |=> (out_valid))
		else $error("item lost between input and result register");

endmodule

`default_nettype wire

@@ tb/relay_controller_checker.sv @@
// ----------------------------------------------------------------------------
// relay_controller_checker: result checker of the start relay controller
// Follows register writes and accepted items, predicts the result of each
// item from its own copy of filter, window and phase state, and compares
// every accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module relay_controller_checker
	import cssrc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire logic                  kind,
	input  wire logic [9:0]            sample,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire logic                  start_relay_on,
	input  wire logic                  alarm_relay_on,
	input  wire logic [1:0]            tone_event,
	input  wire logic                  window_done,
	input  wire logic [9:0]            window_peak,
	input  wire logic [9:0]            filtered_value,
	input  wire logic [1:0]            start_result,
	output int                         mismatches,
	output int                         pending
);

	typedef enum logic [2:0] {
		PH_INIT,
		PH_MEASURE,
		PH_STARTING,
		PH_ALARM,
		PH_PAUSE
	} ctl_phase_e;

	typedef struct packed {
		logic       start_relay_on;
		logic       alarm_relay_on;
		logic [1:0] tone_event;
		logic       window_done;
		logic [9:0] window_peak;
		logic [9:0] filtered_value;
		logic [1:0] start_result;
	} relay_status_t;

	// register copies
	logic [THR_W-1:0]  thr_reg;
	logic [WIN_W-1:0]  win_reg;
	logic [TIME_W-1:0] timeout_reg;
	logic [TIME_W-1:0] pause_reg;
	logic [TIME_W-1:0] alarm_reg;

	// controller state
	logic [12:0]       avg_sum;
	bit                avg_seeded;
	logic [9:0]        win_peak;
	logic [9:0]        win_ticks;
	ctl_phase_e        ctl_phase;
	logic [15:0]       hold_timer;
	logic [15:0]       start_timer;

	relay_status_t     expected_status_q[$];

	function automatic logic [9:0] filter_level();
		logic [9:0] level;
		level = 10'(avg_sum / AVERAGE_DEPTH_DEF);
		return avg_seeded ? level : 10'd0;
	endfunction

	// one item through filter, window and phase sequencer
	function automatic relay_status_t advance_controller(logic is_tick, logic [9:0] smp);
		relay_status_t st;
		logic [9:0]    level;
		logic [9:0]    win_len;
		bit            measuring;
		st = '0;
		measuring = (ctl_phase == PH_INIT) || (ctl_phase == PH_MEASURE) ||
			(ctl_phase == PH_STARTING);
		if (is_tick == KIND_SAMPLE) begin
			// samples outside a window leave the filter alone
			if (measuring) begin
				if (!avg_seeded) begin
					avg_sum = 13'(smp * AVERAGE_DEPTH_DEF);
					avg_seeded = 1'b1;
				end else begin
					avg_sum = 13'(avg_sum - avg_sum / AVERAGE_DEPTH_DEF + smp);
				end
				level = filter_level();
				if (level > win_peak)
					win_peak = level;
			end
		end else begin
			// window bookkeeping, a zero length counts as one tick
			if (measuring) begin
				win_len = (win_reg == '0) ? 10'd1 : win_reg;
				win_ticks = win_ticks + 10'd1;
				if (win_ticks >= win_len) begin
					st.window_done = 1'b1;
					st.window_peak = win_peak;
					win_peak = '0;
					win_ticks = '0;
				end
			end
			case (ctl_phase)
			PH_INIT: begin
				if (st.window_done) begin
					st.tone_event = TONE_READY;
					ctl_phase = PH_MEASURE;
				end
			end
			PH_MEASURE: begin
				if (st.window_done) begin
					if (st.window_peak > thr_reg) begin
						st.tone_event = TONE_START;
						start_timer = '0;
						ctl_phase = PH_STARTING;
					end else begin
						hold_timer = '0;
						ctl_phase = PH_PAUSE;
					end
				end
			end
			PH_STARTING: begin
				// success takes precedence over a timeout on the same tick
				start_timer = start_timer + 16'd1;
				if (st.window_done && st.window_peak < thr_reg) begin
					st.start_result = RES_OK;
					hold_timer = '0;
					ctl_phase = PH_PAUSE;
				end else if (start_timer >= timeout_reg) begin
					st.start_result = RES_TIMEOUT;
					st.tone_event = TONE_FAIL;
					hold_timer = '0;
					ctl_phase = PH_ALARM;
					win_peak = '0;
					win_ticks = '0;
				end
			end
			PH_ALARM: begin
				hold_timer = hold_timer + 16'd1;
				if (hold_timer >= alarm_reg) begin
					hold_timer = '0;
					ctl_phase = PH_PAUSE;
				end
			end
			default: begin
				hold_timer = hold_timer + 16'd1;
				if (hold_timer >= pause_reg) begin
					hold_timer = '0;
					win_peak = '0;
					win_ticks = '0;
					ctl_phase = PH_MEASURE;
				end
			end
			endcase
		end
		st.start_relay_on = (ctl_phase == PH_STARTING);
		st.alarm_relay_on = (ctl_phase == PH_ALARM);
		st.filtered_value = filter_level();
		return st;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t: relay controller result error: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(string field, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
	endtask

	// follow writes, compare results, predict accepted items
	always @(posedge clk or negedge arst_n) begin
		relay_status_t want;
		if (!arst_n) begin
			thr_reg = THRESHOLD_RST;
			win_reg = WINDOW_RST;
			timeout_reg = TIMEOUT_RST;
			pause_reg = PAUSE_RST;
			alarm_reg = ALARM_HOLD_RST;
			avg_sum = '0;
			avg_seeded = 1'b0;
			win_peak = '0;
			win_ticks = '0;
			ctl_phase = PH_INIT;
			hold_timer = '0;
			start_timer = '0;
			expected_status_q.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_START_THRESHOLD:  thr_reg = cfg_data[THR_W-1:0];
				REG_WINDOW_MS:        win_reg = cfg_data[WIN_W-1:0];
				REG_START_TIMEOUT_MS: timeout_reg = cfg_data;
				REG_PAUSE_MS:         pause_reg = cfg_data;
				REG_ALARM_HOLD_MS:    alarm_reg = cfg_data;
				default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_status_q.size() == 0) begin
					report_mismatch("result item with nothing expected");
				end else begin
					want = expected_status_q.pop_front();
					check_field("start_relay_on", start_relay_on, want.start_relay_on);
					check_field("alarm_relay_on", alarm_relay_on, want.alarm_relay_on);
					check_field("tone_event", tone_event, want.tone_event);
					check_field("window_done", window_done, want.window_done);
					check_field("window_peak", window_peak, want.window_peak);
					check_field("filtered_value", filtered_value, want.filtered_value);
					check_field("start_result", start_result, want.start_result);
				end
			end
			if (in_valid && !in_stall)
				expected_status_q.push_back(advance_controller(kind, sample));
			pending = expected_status_q.size();
		end
	end

endmodule

`default_nettype wire

@@ tb/current_sensed_start_relay_controller_top_test.sv @@
// ----------------------------------------------------------------------------
// current_sensed_start_relay_controller_top_test: start relay controller bench
// Drives sample and tick items through a sequence of register settings, first
// a directed walk through every phase, then current bursts shaped to start,
// succeed and time out, with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module current_sensed_start_relay_controller_top_test;
	import cssrc_pkg::*;

	localparam int RESULT_LATENCY = 2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_ALARM_HOLD_MS + 3'd1;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  kind;
	logic [9:0]            sample;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  start_relay_on;
	logic                  alarm_relay_on;
	logic [1:0]            tone_event;
	logic                  window_done;
	logic [9:0]            window_peak;
	logic [9:0]            filtered_value;
	logic [1:0]            start_result;
	int                    mismatches;
	int                    pending;
	int                    stall_left;
	bit                    calm;

	current_sensed_start_relay_controller_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.start_relay_on (start_relay_on),
		.alarm_relay_on (alarm_relay_on),
		.tone_event     (tone_event),
		.window_done    (window_done),
		.window_peak    (window_peak),
		.filtered_value (filtered_value),
		.start_result   (start_result)
	);

	relay_controller_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.start_relay_on (start_relay_on),
		.alarm_relay_on (alarm_relay_on),
		.tone_event     (tone_event),
		.window_done    (window_done),
		.window_peak    (window_peak),
		.filtered_value (filtered_value),
		.start_result   (start_result),
		.mismatches     (mismatches),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side stalls in random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (calm) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 6);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// one item, with an occasional gap ahead of it
	task automatic drive_item(logic k, logic [9:0] s);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		sample <= s;
		do @(posedge clk); while (in_stall);
	endtask

	// hold off until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic apply_settings(logic [15:0] thr, logic [15:0] win, logic [15:0] timeout,
			logic [15:0] pause, logic [15:0] hold);
		drain();
		repeat (RESULT_LATENCY) @(posedge clk);
		write_reg(REG_START_THRESHOLD, thr);
		write_reg(REG_WINDOW_MS, win);
		write_reg(REG_START_TIMEOUT_MS, timeout);
		write_reg(REG_PAUSE_MS, pause);
		write_reg(REG_ALARM_HOLD_MS, hold);
		cfg_we <= 1'b0;
	endtask

	// segments of ticks carrying high, low, no or random current
	task automatic run_traffic(int budget);
		int         sent;
		int         mode;
		int         ticks;
		int         burst;
		int         t;
		int         b;
		logic [9:0] level;
		sent = 0;
		while (sent < budget) begin
			mode = $urandom_range(0, 9);
			ticks = $urandom_range(1, 6);
			for (t = 0; t < ticks; t++) begin
				burst = (mode == 7) ? 0 : $urandom_range(0, 3);
				for (b = 0; b < burst; b++) begin
					if (mode <= 3)
						level = $urandom_range(0, 1) ? 10'd1023 : 10'($urandom_range(800, 1023));
					else if (mode <= 6)
						level = $urandom_range(0, 3) == 0 ? 10'd0 : 10'($urandom_range(0, 150));
					else
						level = 10'($urandom_range(0, 1023));
					drive_item(KIND_SAMPLE, level);
					sent++;
				end
				drive_item(KIND_TICK, 10'($urandom_range(0, 1023)));
				sent++;
			end
		end
	endtask

	initial begin
		in_valid <= 1'b0;
		kind <= KIND_SAMPLE;
		sample <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_START_THRESHOLD;
		cfg_data <= '0;
		calm = 1'b0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: first sample seeds the filter, then extremes
		drive_item(KIND_SAMPLE, 10'd1023);
		drive_item(KIND_SAMPLE, 10'd0);
		drive_item(KIND_SAMPLE, 10'd512);
		drive_item(KIND_TICK, 10'd0);
		drive_item(KIND_TICK, 10'd1023);

		// zero window, timeout, pause and hold: every phase in a few ticks
		apply_settings(16'd500, 16'd0, 16'd0, 16'd0, 16'd0);
		drive_item(KIND_TICK, 10'd0);
		drive_item(KIND_SAMPLE, 10'd1023);
		drive_item(KIND_TICK, 10'd0);
		// empty window while starting: success beats the expired timer
		drive_item(KIND_TICK, 10'd0);
		drive_item(KIND_TICK, 10'd0);
		drive_item(KIND_TICK, 10'd0);
		drive_item(KIND_TICK, 10'd0);
		drive_item(KIND_SAMPLE, 10'd1023);
		drive_item(KIND_TICK, 10'd0);
		// high window while starting: timeout into alarm
		drive_item(KIND_SAMPLE, 10'd0);
		drive_item(KIND_TICK, 10'd0);
		// samples during alarm and pause are ignored
		drive_item(KIND_SAMPLE, 10'd1023);
		drive_item(KIND_TICK, 10'd0);
		drive_item(KIND_SAMPLE, 10'd5);
		drive_item(KIND_TICK, 10'd0);

		// random current bursts under several settings
		apply_settings(16'd600, 16'd3, 16'd20, 16'd4, 16'd5);
		run_traffic(110);
		drain();
		run_traffic(110);
		apply_settings(16'd300, 16'd1, 16'd1, 16'd0, 16'd0);
		run_traffic(200);
		apply_settings(16'd0, 16'd2, 16'd10, 16'd2, 16'd3);
		run_traffic(150);
		apply_settings(16'd1023, 16'd2, 16'd8, 16'd1, 16'd2);
		run_traffic(150);
		repeat (3) begin
			apply_settings(16'($urandom_range(200, 900)), 16'($urandom_range(1, 6)),
				16'($urandom_range(1, 60)), 16'($urandom_range(0, 10)),
				16'($urandom_range(0, 12)));
			run_traffic(200);
		end

		// all registers at full scale, plus a write to an unused index
		apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
		cfg_we <= 1'b0;
		run_traffic(40);

		// closing stretch, the last part without idling
		apply_settings(16'd700, 16'd4, 16'd25, 16'd3, 16'd4);
		run_traffic(150);
		calm = 1'b1;
		run_traffic(150);

		drain();
		repeat (RESULT_LATENCY + 4) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("current_sensed_start_relay_controller_top: match");
		else
			$display("current_sensed_start_relay_controller_top: mismatch");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("current_sensed_start_relay_controller_top: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

@@ current_sensed_start_relay_controller_top.f @@
rtl/cssrc_pkg.sv
rtl/cssrc_filter.sv
rtl/cssrc_seq.sv
rtl/current_sensed_start_relay_controller_top.sv
tb/relay_controller_checker.sv
tb/current_sensed_start_relay_controller_top_test.sv
